// File: rtl/psod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_pkg
// Shared widths, reset values, register indexes and types for the polar
// sector occupancy detector.
// ----------------------------------------------------------------------------
package psod_pkg;

  // Field widths
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned MASK_W     = 48;

  // Sector store: sized for the largest sector count
  localparam int unsigned MAX_SECTORS = 48;
  localparam int unsigned SEC_W       = $clog2(MAX_SECTORS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [DIST_W-1:0] WINDOW_MIN_RST = DIST_W'(1600);
  localparam logic [DIST_W-1:0] WINDOW_MAX_RST = DIST_W'(2000);
  localparam logic [THR_W-1:0]  MATCH_THR_RST  = THR_W'(4);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MIN = 2'd0,
    REG_WINDOW_MAX = 2'd1,
    REG_MATCH_THR  = 2'd2
  } cfg_reg_e;

  // Classified point handed to the sector update stage
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic             hit;
    logic             last;
  } point_t;

endpackage

// File: rtl/psod_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_cfg_regs
// Distance window and match threshold registers behind a plain write port.
// ----------------------------------------------------------------------------
module psod_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psod_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [psod_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic [psod_pkg::DIST_W-1:0]        window_min_o,
  output logic [psod_pkg::DIST_W-1:0]        window_max_o,
  output logic [psod_pkg::THR_W-1:0]         match_thr_o
);

  logic [psod_pkg::DIST_W-1:0] win_min_q, win_min_d;
  logic [psod_pkg::DIST_W-1:0] win_max_q, win_max_d;
  logic [psod_pkg::THR_W-1:0]  thr_q, thr_d;

  // Decode writes; unknown indexes are dropped
  always_comb begin
    win_min_d = win_min_q;
    win_max_d = win_max_q;
    thr_d     = thr_q;
    if (cfg_we_i) begin
      case (psod_pkg::cfg_reg_e'(cfg_idx_i))
        psod_pkg::REG_WINDOW_MIN: win_min_d = cfg_wdata_i[psod_pkg::DIST_W-1:0];
        psod_pkg::REG_WINDOW_MAX: win_max_d = cfg_wdata_i[psod_pkg::DIST_W-1:0];
        psod_pkg::REG_MATCH_THR:  thr_d     = cfg_wdata_i[psod_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_min_q <= psod_pkg::WINDOW_MIN_RST;
      win_max_q <= psod_pkg::WINDOW_MAX_RST;
      thr_q     <= psod_pkg::MATCH_THR_RST;
    end else begin
      win_min_q <= win_min_d;
      win_max_q <= win_max_d;
      thr_q     <= thr_d;
    end
  end

  assign window_min_o = win_min_q;
  assign window_max_o = win_max_q;
  assign match_thr_o  = thr_q;

endmodule

// File: rtl/psod_point_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_point_classify
// Maps a point's angle to its sector and checks its distance against the
// half-open window.
// ----------------------------------------------------------------------------
module psod_point_classify #(
  parameter int unsigned SECTORS = psod_pkg::MAX_SECTORS
) (
  input  logic [psod_pkg::ANGLE_W-1:0] angle_raw_i,
  input  logic [psod_pkg::DIST_W-1:0]  distance_q2_i,
  input  logic                         last_point_i,
  input  logic [psod_pkg::DIST_W-1:0]  window_min_i,
  input  logic [psod_pkg::DIST_W-1:0]  window_max_i,
  output psod_pkg::point_t             point_o
);

  localparam int unsigned ProdW = psod_pkg::ANGLE_W + psod_pkg::SEC_W;

  logic [psod_pkg::SEC_W-1:0] sectors_c;
  logic [ProdW-1:0]           angle_prod;

  assign sectors_c = psod_pkg::SEC_W'(SECTORS);

  // Sector = angle * SECTORS >> 16, always below SECTORS
  assign angle_prod = ProdW'(angle_raw_i) * ProdW'(sectors_c);

  always_comb begin
    point_o.sector = angle_prod[ProdW-1:psod_pkg::ANGLE_W];
    // zero distance is an invalid sample
    point_o.hit    = (distance_q2_i != '0) &&
                     (distance_q2_i >= window_min_i) &&
                     (distance_q2_i <  window_max_i);
    point_o.last   = last_point_i;
  end

endmodule

// File: rtl/psod_sector_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psod_sector_update
// Per-sector counter memory with read-modify-write, entry valid bits for the
// end-of-scan clear, detected flags and the mask of a finished scan.
// ----------------------------------------------------------------------------
module psod_sector_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_fire_i,
  input  psod_pkg::point_t             point_i,
  input  logic [psod_pkg::THR_W-1:0]   match_thr_i,
  input  logic                         out_free_i,
  output logic                         in_ready_o,
  output logic                         emit_o,
  output logic [psod_pkg::MASK_W-1:0]  mask_o
);

  localparam int unsigned Depth = psod_pkg::MAX_SECTORS;
  localparam int unsigned CntW  = psod_pkg::CNT_W;

  // Counter memory with a registered read
  logic [CntW-1:0] cnt_mem [Depth];
  logic [CntW-1:0] rd_q;

  // Stage 1 holds the point whose counter is being updated
  logic             s1_valid_q, s1_valid_d;
  psod_pkg::point_t s1_q;
  logic             s1_fire;

  // Write-to-read bypass for back-to-back hits on the same sector
  logic            byp_q, byp_d;
  logic [CntW-1:0] byp_data_q;

  logic [Depth-1:0] ent_valid_q, ent_valid_d;
  logic [Depth-1:0] det_q, det_d;

  logic [CntW-1:0] cnt_cur, cnt_new;
  logic [CntW:0]   cap;
  logic            now_det;
  logic            wr_en;
  logic [Depth-1:0] sec_bit;

  assign s1_fire    = s1_valid_q && (!s1_q.last || out_free_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign wr_en      = s1_fire && s1_q.hit;
  assign sec_bit    = Depth'(1) << s1_q.sector;

  // Counter update: saturate at threshold + 1, capped at the counter range
  always_comb begin
    if (byp_q) begin
      cnt_cur = byp_data_q;
    end else if (ent_valid_q[s1_q.sector]) begin
      cnt_cur = rd_q;
    end else begin
      cnt_cur = '0;
    end
    if (match_thr_i == {psod_pkg::THR_W{1'b1}}) begin
      cap = (CntW+1)'({CntW{1'b1}});
    end else begin
      cap = (CntW+1)'(match_thr_i) + (CntW+1)'(1);
    end
    if ((CntW+1)'(cnt_cur) < cap) begin
      cnt_new = cnt_cur + CntW'(1);
    end else begin
      cnt_new = cnt_cur;
    end
    now_det = s1_q.hit && (cnt_new > CntW'(match_thr_i));
  end

  // Flags, valid bits and stage control
  always_comb begin
    ent_valid_d = ent_valid_q;
    det_d       = det_q;
    if (s1_fire) begin
      if (s1_q.last) begin
        ent_valid_d = '0;
        det_d       = '0;
      end else begin
        if (wr_en)   ent_valid_d = ent_valid_q | sec_bit;
        if (now_det) det_d       = det_q | sec_bit;
      end
    end
    if (in_fire_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    byp_d = wr_en && !s1_q.last && (point_i.sector == s1_q.sector);
  end

  // Finished scan: flags so far plus this point's own detection
  assign emit_o = s1_fire && s1_q.last;
  assign mask_o = psod_pkg::MASK_W'(now_det ? (det_q | sec_bit) : det_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      ent_valid_q <= '0;
      det_q       <= '0;
      byp_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      ent_valid_q <= ent_valid_d;
      det_q       <= det_d;
      if (in_fire_i) byp_q <= byp_d;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_q       <= point_i;
      byp_data_q <= cnt_new;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) cnt_mem[s1_q.sector] <= cnt_new;
    if (in_fire_i) rd_q <= cnt_mem[point_i.sector];
  end

endmodule

// File: rtl/polar_sector_occupancy_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_sector_occupancy_detector_core
// Counts range-scanner points per angular sector inside a distance window
// and reports the detected sectors at the end of each scan.
// ----------------------------------------------------------------------------
// The block takes one point word per clock cycle, unless a last point waits
// on a full output register, and keeps doing so with hits on the same
// sector in consecutive cycles: each point is classified on entry, then its
// sector counter is read from a 48-entry memory and written back from stage
// 1, with a bypass covering a hit on the same sector in the next word. A
// point flagged tlast produces one mask word via the output register; the
// point is held only while a previous mask word still sits in the output
// register unaccepted. Counters and flags clear at once after each last point, so no sweep follows reset or a scan.
// ----------------------------------------------------------------------------
module polar_sector_occupancy_detector_core #(
  parameter int unsigned SECTORS = psod_pkg::MAX_SECTORS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [psod_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psod_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Point stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // angle_raw[15:0], distance_q2[47:16]
  input  logic                              s_axis_tlast,  // last_point
  // Mask stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [psod_pkg::MASK_W-1:0]       m_axis_tdata   // detected_mask[47:0]
);

  logic [psod_pkg::DIST_W-1:0] window_min, window_max;
  logic [psod_pkg::THR_W-1:0]  match_thr;
  psod_pkg::point_t            point;
  logic                        in_fire;
  logic                        out_free;
  logic                        emit;
  logic [psod_pkg::MASK_W-1:0] mask;

  logic                        out_valid_q, out_valid_d;
  logic [psod_pkg::MASK_W-1:0] out_mask_q;

  psod_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .window_min_o (window_min),
    .window_max_o (window_max),
    .match_thr_o  (match_thr)
  );

  psod_point_classify #(
    .SECTORS (SECTORS)
  ) u_classify (
    .angle_raw_i   (s_axis_tdata[psod_pkg::ANGLE_W-1:0]),
    .distance_q2_i (s_axis_tdata[psod_pkg::ANGLE_W +: psod_pkg::DIST_W]),
    .last_point_i  (s_axis_tlast),
    .window_min_i  (window_min),
    .window_max_i  (window_max),
    .point_o       (point)
  );

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  psod_sector_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .point_i     (point),
    .match_thr_i (match_thr),
    .out_free_i  (out_free),
    .in_ready_o  (s_axis_tready),
    .emit_o      (emit),
    .mask_o      (mask)
  );

  // Output register
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_mask_q <= mask;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mask_q;

endmodule
